// File: rtl/core/tvplu_pkg.sv
// ----------------------------------------------------------------------------
// tvplu_pkg
// Types, constants and tie-order tables for the TV pixel label update block.
// ----------------------------------------------------------------------------
package tvplu_pkg;

	localparam int MAX_ROWS   = 256;
	localparam int MAX_COLS   = 256;
	localparam int PIXEL_BITS = 16;

	localparam int CMD_W      = 2;
	localparam int COORD_W    = 8;
	localparam int PIX_IO_W   = 16;
	localparam int WEIGHT_W   = 16;
	localparam int DIM_REG_W  = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int MAX_DIM  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int DIM_W    = ($clog2(MAX_DIM + 1) > DIM_REG_W) ?
		$clog2(MAX_DIM + 1) : DIM_REG_W;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int SUM_W    = PIXEL_BITS + 2;
	localparam int COST_W   = WEIGHT_W + SUM_W + 1;

	localparam int MISMATCH_COST = 256;
	localparam int MIN_DIM       = 3;

	localparam logic [WEIGHT_W-1:0]  WEIGHT_RESET = WEIGHT_W'(256);
	localparam logic [DIM_REG_W-1:0] DIM_RESET    = DIM_REG_W'(256);

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WEIGHT = 2'd0,
		CFG_ROWS   = 2'd1,
		CFG_COLS   = 2'd2,
		CFG_NONE   = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIR_DOWN  = 2'd0,
		DIR_UP    = 2'd1,
		DIR_RIGHT = 2'd2,
		DIR_LEFT  = 2'd3
	} dir_t;

	typedef enum logic [3:0] {
		RGN_INTERIOR     = 4'd0,
		RGN_LEFT         = 4'd1,
		RGN_RIGHT        = 4'd2,
		RGN_TOP          = 4'd3,
		RGN_TOP_LEFT     = 4'd4,
		RGN_TOP_RIGHT    = 4'd5,
		RGN_BOTTOM       = 4'd6,
		RGN_BOTTOM_LEFT  = 4'd7,
		RGN_BOTTOM_RIGHT = 4'd8
	} region_t;

	function automatic logic [2:0] region_cnt(input region_t rgn);
		logic [2:0] n;
		unique case (rgn)
			RGN_INTERIOR: n = 3'd4;
			RGN_LEFT, RGN_RIGHT, RGN_TOP, RGN_BOTTOM: n = 3'd3;
			default: n = 3'd2;
		endcase
		return n;
	endfunction

	// Neighbor visiting order per region, which is also the tie order.
	function automatic dir_t region_dir(input region_t rgn, input logic [1:0] k);
		dir_t d;
		d = DIR_DOWN;
		unique case (rgn)
			RGN_INTERIOR: begin
				unique case (k)
					2'd0: d = DIR_DOWN;
					2'd1: d = DIR_UP;
					2'd2: d = DIR_RIGHT;
					default: d = DIR_LEFT;
				endcase
			end
			RGN_LEFT: begin
				unique case (k)
					2'd0: d = DIR_UP;
					2'd1: d = DIR_RIGHT;
					default: d = DIR_DOWN;
				endcase
			end
			RGN_RIGHT: begin
				unique case (k)
					2'd0: d = DIR_UP;
					2'd1: d = DIR_LEFT;
					default: d = DIR_DOWN;
				endcase
			end
			RGN_TOP: begin
				unique case (k)
					2'd0: d = DIR_LEFT;
					2'd1: d = DIR_DOWN;
					default: d = DIR_RIGHT;
				endcase
			end
			RGN_TOP_LEFT: d = (k == 2'd0) ? DIR_RIGHT : DIR_DOWN;
			RGN_TOP_RIGHT: d = (k == 2'd0) ? DIR_DOWN : DIR_LEFT;
			RGN_BOTTOM: begin
				unique case (k)
					2'd0: d = DIR_LEFT;
					2'd1: d = DIR_UP;
					default: d = DIR_RIGHT;
				endcase
			end
			RGN_BOTTOM_LEFT: d = (k == 2'd0) ? DIR_RIGHT : DIR_UP;
			RGN_BOTTOM_RIGHT: d = (k == 2'd0) ? DIR_UP : DIR_LEFT;
			default: d = DIR_DOWN;
		endcase
		return d;
	endfunction

endpackage

// File: rtl/core/tvplu_if.sv
// ----------------------------------------------------------------------------
// tvplu_if
// Valid/ready channel interfaces: item, result and configuration write.
// ----------------------------------------------------------------------------
interface tvplu_item_if;
	logic                             valid;
	logic                             ready;
	logic [tvplu_pkg::CMD_W-1:0]      command;
	logic [tvplu_pkg::COORD_W-1:0]    row;
	logic [tvplu_pkg::COORD_W-1:0]    col;
	logic [tvplu_pkg::PIX_IO_W-1:0]   pixel_in;

	modport source (output valid, command, row, col, pixel_in, input ready);
	modport sink (input valid, command, row, col, pixel_in, output ready);
endinterface

interface tvplu_result_if;
	logic                             valid;
	logic                             ready;
	logic [tvplu_pkg::PIX_IO_W-1:0]   pixel_out;
	logic                             changed;
	logic                             status;

	modport source (output valid, pixel_out, changed, status, input ready);
	modport sink (input valid, pixel_out, changed, status, output ready);
endinterface

interface tvplu_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [tvplu_pkg::CFG_IDX_W-1:0]  index;
	logic [tvplu_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/tv_pixel_label_update.sv
// ----------------------------------------------------------------------------
// tv_pixel_label_update
// ICM total-variation denoise step over an observed and a current image.
// ----------------------------------------------------------------------------
// channel | dir  | payload
// item    | sink | command, row, col, pixel_in
// res     | src  | pixel_out, changed, status
// cfg     | sink | index, data (always ready)
//
// Load, invalid coordinate or unused command: result given from decode.
// Read: result after a read-wait state. Update: fetch the n in-bounds
// neighbors (2..4) over the single read port of the current image (one neighbor
// a cycle), then run the shared cost unit (sum, multiply, compare) on n + 1 candidates.
// Reset clears control and config only; image memories are not cleared.
// A stalled result holds in the output register; an item is taken meanwhile.
// ----------------------------------------------------------------------------
module tv_pixel_label_update (
	input logic                clk,
	input logic                arst_n,
	tvplu_item_if.sink         item,
	tvplu_result_if.source     res,
	tvplu_cfg_if.sink          cfg
);

	localparam int PW = tvplu_pkg::PIXEL_BITS;
	localparam int AW = tvplu_pkg::ADDR_W;
	localparam int DW = tvplu_pkg::DIM_W;
	localparam int SW = tvplu_pkg::SUM_W;
	localparam int CW = tvplu_pkg::COST_W;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_DECODE = 9'b000000010,
		ST_RDWAIT = 9'b000000100,
		ST_FETCH  = 9'b000001000,
		ST_FDRAIN = 9'b000010000,
		ST_SUM    = 9'b000100000,
		ST_MUL    = 9'b001000000,
		ST_CMP    = 9'b010000000,
		ST_WRITE  = 9'b100000000
	} state_t;

	function automatic logic [PW-1:0] absdiff(input logic [PW-1:0] a, input logic [PW-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	state_t state_q, state_d;

	// configuration
	logic [tvplu_pkg::WEIGHT_W-1:0]  weight_q;
	logic [tvplu_pkg::DIM_REG_W-1:0] rows_q, cols_q;

	// captured item
	tvplu_pkg::cmd_t             cmd_q;
	logic [tvplu_pkg::COORD_W-1:0] row_q, col_q;
	logic [PW-1:0]               pin_q;

	// update context
	logic [AW-1:0]               addr_q;
	tvplu_pkg::region_t          region_q;
	logic [2:0]                  cnt_q;
	logic [2:0]                  fidx_q, fidx_d;
	logic [2:0]                  cand_idx_q, cand_idx_d;
	logic [PW-1:0]               nb_q [4];
	logic [PW-1:0]               old_q;
	logic [PW-1:0]               cand_q;
	logic [SW-1:0]               sum_q;
	logic [CW-1:0]               cost_q;
	logic [CW-1:0]               best_cost_q;
	logic [PW-1:0]               best_q;

	// read capture
	logic                        cap_vld_q;
	logic                        cap_own_q;
	logic [1:0]                  cap_idx_q;

	// memories
	logic [PW-1:0]               obs_mem [tvplu_pkg::DEPTH];
	logic [PW-1:0]               cur_mem [tvplu_pkg::DEPTH];
	logic [PW-1:0]               obs_rd_q, cur_rd_q;
	logic                        obs_re, cur_re, obs_we, cur_we;
	logic [AW-1:0]               cur_ra;
	logic [PW-1:0]               cur_wd;
	logic [AW-1:0]               cur_wa;

	// result register
	logic                        res_vld_q;
	logic [tvplu_pkg::PIX_IO_W-1:0] res_pix_q, res_pix_d;
	logic                        res_chg_q, res_chg_d;
	logic                        res_st_q, res_st_d;
	logic                        res_load;
	logic                        out_free;

	// decode
	logic [DW-1:0]               eff_rows, eff_cols;
	logic                        in_range;
	logic                        top, bottom, left, right;
	tvplu_pkg::region_t          region_c;
	logic [AW-1:0]               addr_c;
	logic [AW-1:0]               nb_addr;
	tvplu_pkg::dir_t             nb_dir;
	logic [PW-1:0]               cand_c;
	logic [1:0]                  cand_m1;
	logic [SW-1:0]               sum_c;
	logic                        mismatch;

	assign cfg.ready  = 1'b1;
	assign item.ready = (state_q == ST_IDLE);
	assign out_free   = !res_vld_q || res.ready;

	always_comb begin
		eff_rows = DW'(rows_q);
		if (DW'(rows_q) < DW'(tvplu_pkg::MIN_DIM)) eff_rows = DW'(tvplu_pkg::MIN_DIM);
		else if (DW'(rows_q) > DW'(tvplu_pkg::MAX_ROWS)) eff_rows = DW'(tvplu_pkg::MAX_ROWS);
		eff_cols = DW'(cols_q);
		if (DW'(cols_q) < DW'(tvplu_pkg::MIN_DIM)) eff_cols = DW'(tvplu_pkg::MIN_DIM);
		else if (DW'(cols_q) > DW'(tvplu_pkg::MAX_COLS)) eff_cols = DW'(tvplu_pkg::MAX_COLS);
	end

	assign in_range = (DW'(row_q) < eff_rows) && (DW'(col_q) < eff_cols);
	assign top      = (row_q == '0);
	assign bottom   = (DW'(row_q) == eff_rows - DW'(1));
	assign left     = (col_q == '0);
	assign right    = (DW'(col_q) == eff_cols - DW'(1));
	assign addr_c   = AW'(AW'(row_q) * AW'(tvplu_pkg::MAX_COLS)) + AW'(col_q);

	always_comb begin
		priority if (top) begin
			region_c = left ? tvplu_pkg::RGN_TOP_LEFT :
				right ? tvplu_pkg::RGN_TOP_RIGHT : tvplu_pkg::RGN_TOP;
		end else if (bottom) begin
			region_c = left ? tvplu_pkg::RGN_BOTTOM_LEFT :
				right ? tvplu_pkg::RGN_BOTTOM_RIGHT : tvplu_pkg::RGN_BOTTOM;
		end else begin
			region_c = left ? tvplu_pkg::RGN_LEFT :
				right ? tvplu_pkg::RGN_RIGHT : tvplu_pkg::RGN_INTERIOR;
		end
	end

	assign nb_dir = tvplu_pkg::region_dir(region_q, fidx_q[1:0]);
	always_comb begin
		unique case (nb_dir)
			tvplu_pkg::DIR_DOWN:  nb_addr = addr_q + AW'(tvplu_pkg::MAX_COLS);
			tvplu_pkg::DIR_UP:    nb_addr = addr_q - AW'(tvplu_pkg::MAX_COLS);
			tvplu_pkg::DIR_RIGHT: nb_addr = addr_q + AW'(1);
			default:              nb_addr = addr_q - AW'(1);
		endcase
	end

	// shared cost unit: sum of absolute differences of one candidate
	assign cand_m1 = 2'(cand_idx_q - 3'd1);
	assign cand_c  = (cand_idx_q == 3'd0) ? obs_rd_q : nb_q[cand_m1];
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < cnt_q) sum_c = sum_c + SW'(absdiff(cand_c, nb_q[i]));
		end
	end
	assign mismatch = (cand_idx_q != 3'd0) && (cand_q != obs_rd_q);

	// sequencer
	always_comb begin
		state_d    = state_q;
		fidx_d     = fidx_q;
		cand_idx_d = cand_idx_q;
		obs_re     = 1'b0;
		cur_re     = 1'b0;
		cur_ra     = addr_c;
		obs_we     = 1'b0;
		cur_we     = 1'b0;
		cur_wa     = addr_c;
		cur_wd     = pin_q;
		res_load   = 1'b0;
		res_pix_d  = '0;
		res_chg_d  = 1'b0;
		res_st_d   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (cmd_q == tvplu_pkg::CMD_NOP || !in_range) begin
					if (out_free) begin
						res_load = 1'b1;
						res_st_d = (cmd_q != tvplu_pkg::CMD_NOP);
						state_d  = ST_IDLE;
					end
				end else begin
					unique case (cmd_q)
						tvplu_pkg::CMD_LOAD: begin
							if (out_free) begin
								obs_we    = 1'b1;
								cur_we    = 1'b1;
								res_load  = 1'b1;
								res_pix_d = tvplu_pkg::PIX_IO_W'(pin_q);
								state_d   = ST_IDLE;
							end
						end
						tvplu_pkg::CMD_READ: begin
							cur_re  = 1'b1;
							state_d = ST_RDWAIT;
						end
						default: begin
							cur_re  = 1'b1;
							obs_re  = 1'b1;
							fidx_d  = '0;
							state_d = ST_FETCH;
						end
					endcase
				end
			end
			ST_RDWAIT: begin
				if (out_free) begin
					res_load  = 1'b1;
					res_pix_d = tvplu_pkg::PIX_IO_W'(cur_rd_q);
					state_d   = ST_IDLE;
				end
			end
			ST_FETCH: begin
				cur_re = 1'b1;
				cur_ra = nb_addr;
				if (fidx_q == cnt_q - 3'd1) state_d = ST_FDRAIN;
				else fidx_d = fidx_q + 3'd1;
			end
			ST_FDRAIN: begin
				cand_idx_d = '0;
				state_d    = ST_SUM;
			end
			ST_SUM: state_d = ST_MUL;
			ST_MUL: state_d = ST_CMP;
			ST_CMP: begin
				if (cand_idx_q == cnt_q) begin
					state_d = ST_WRITE;
				end else begin
					cand_idx_d = cand_idx_q + 3'd1;
					state_d    = ST_SUM;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					cur_we    = 1'b1;
					cur_wa    = addr_q;
					cur_wd    = best_q;
					res_load  = 1'b1;
					res_pix_d = tvplu_pkg::PIX_IO_W'(best_q);
					res_chg_d = (best_q != old_q);
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fidx_q     <= '0;
			cand_idx_q <= '0;
			cap_vld_q  <= 1'b0;
			res_vld_q  <= 1'b0;
			weight_q   <= tvplu_pkg::WEIGHT_RESET;
			rows_q     <= tvplu_pkg::DIM_RESET;
			cols_q     <= tvplu_pkg::DIM_RESET;
		end else begin
			state_q    <= state_d;
			fidx_q     <= fidx_d;
			cand_idx_q <= cand_idx_d;
			cap_vld_q  <= cur_re;
			if (res_load) res_vld_q <= 1'b1;
			else if (res.ready) res_vld_q <= 1'b0;
			if (cfg.valid) begin
				unique case (tvplu_pkg::cfg_idx_t'(cfg.index))
					tvplu_pkg::CFG_WEIGHT: weight_q <= cfg.data;
					tvplu_pkg::CFG_ROWS:   rows_q <= cfg.data[tvplu_pkg::DIM_REG_W-1:0];
					tvplu_pkg::CFG_COLS:   cols_q <= cfg.data[tvplu_pkg::DIM_REG_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			cmd_q <= tvplu_pkg::cmd_t'(item.command);
			row_q <= item.row;
			col_q <= item.col;
			pin_q <= PW'(item.pixel_in);
		end
		if (state_q == ST_DECODE) begin
			addr_q   <= addr_c;
			region_q <= region_c;
			cnt_q    <= tvplu_pkg::region_cnt(region_c);
		end
		cap_own_q <= (state_q == ST_DECODE);
		cap_idx_q <= fidx_q[1:0];
		if (cap_vld_q) begin
			if (cap_own_q) old_q <= cur_rd_q;
			else nb_q[cap_idx_q] <= cur_rd_q;
		end
		if (state_q == ST_SUM) begin
			sum_q  <= sum_c;
			cand_q <= cand_c;
		end
		if (state_q == ST_MUL) begin
			cost_q <= CW'(CW'(weight_q) * CW'(sum_q))
				+ (mismatch ? CW'(tvplu_pkg::MISMATCH_COST) : CW'(0));
		end
		if (state_q == ST_CMP && (cand_idx_q == 3'd0 || cost_q < best_cost_q)) begin
			best_cost_q <= cost_q;
			best_q      <= cand_q;
		end
		if (res_load) begin
			res_pix_q <= res_pix_d;
			res_chg_q <= res_chg_d;
			res_st_q  <= res_st_d;
		end
	end

	// observed image
	always_ff @(posedge clk) begin
		if (obs_we) obs_mem[addr_c] <= pin_q;
		if (obs_re) obs_rd_q <= obs_mem[addr_c];
	end

	// current image
	always_ff @(posedge clk) begin
		if (cur_we) cur_mem[cur_wa] <= cur_wd;
		if (cur_re) cur_rd_q <= cur_mem[cur_ra];
	end

	assign res.valid     = res_vld_q;
	assign res.pixel_out = res_pix_q;
	assign res.changed   = res_chg_q;
	assign res.status    = res_st_q;

`ifndef SYNTHESIS
	a_fetch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> (fidx_q < cnt_q))
		else $error("neighbor fetch index past neighbor count");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("item taken while previous one in flight");

	a_write_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && out_free) |=> res.valid)
		else $error("update write without result");

	a_changed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.changed) |-> !res.status)
		else $error("changed flagged on error result");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for tv_pixel_label_update. Loads, updates, reads and
// unused commands are sent over several image sizes and smoothing weights.
// A local model of the observed and current images predicts every result,
// and each received result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
	import tvplu_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_ITEMS    = 110;
	localparam int FILL_LIMIT     = 64;

	typedef struct {
		cmd_t                cmd;
		logic [COORD_W-1:0]  row;
		logic [COORD_W-1:0]  col;
		logic [PIX_IO_W-1:0] pixel_in;
	} pixel_cmd_t;

	typedef struct {
		logic [PIX_IO_W-1:0] pixel_out;
		logic                changed;
		logic                status;
	} pixel_result_t;

	logic clk;
	logic arst_n;

	tvplu_item_if   item_ch ();
	tvplu_result_if res_ch ();
	tvplu_cfg_if    cfg_ch ();

	tv_pixel_label_update u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	logic [PIX_IO_W-1:0]  observed_img [DEPTH];
	logic [PIX_IO_W-1:0]  current_img  [DEPTH];
	bit                   loaded       [DEPTH];
	int                   nbr_addr     [4];
	logic [WEIGHT_W-1:0]  weight_q;
	logic [DIM_REG_W-1:0] rows_q;
	logic [DIM_REG_W-1:0] cols_q;

	pixel_result_t results_due [$];
	int            error_count = 0;
	int            idle_cycles = 0;
	int            stall_left;
	bit            item_quiet = 1'b0;
	bit            res_quiet  = 1'b0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int eff_dim(input logic [DIM_REG_W-1:0] v, input int maxv);
		if (v < MIN_DIM) return MIN_DIM;
		if (v > maxv) return maxv;
		return v;
	endfunction

	// Fills nbr_addr in tie order for the pixel's region; returns the count.
	function automatic int gather_neighbors(input int r, input int c, input int nr,
			input int nc);
		dir_t    ord [4];
		region_t rgn;
		int      cnt;
		int      vr;
		int      vc;
		int      base;
		vr = (r == 0) ? 1 : (r == nr - 1) ? 2 : 0;
		vc = (c == 0) ? 1 : (c == nc - 1) ? 2 : 0;
		rgn = region_t'(vr * 3 + vc);
		base = r * MAX_COLS + c;
		cnt = 3;
		ord = '{DIR_DOWN, DIR_UP, DIR_RIGHT, DIR_LEFT};
		case (rgn)
			RGN_INTERIOR: cnt = 4;
			RGN_LEFT: ord = '{DIR_UP, DIR_RIGHT, DIR_DOWN, DIR_DOWN};
			RGN_RIGHT: ord = '{DIR_UP, DIR_LEFT, DIR_DOWN, DIR_DOWN};
			RGN_TOP: ord = '{DIR_LEFT, DIR_DOWN, DIR_RIGHT, DIR_DOWN};
			RGN_BOTTOM: ord = '{DIR_LEFT, DIR_UP, DIR_RIGHT, DIR_DOWN};
			RGN_TOP_LEFT: begin
				cnt = 2;
				ord = '{DIR_RIGHT, DIR_DOWN, DIR_DOWN, DIR_DOWN};
			end
			RGN_TOP_RIGHT: begin
				cnt = 2;
				ord = '{DIR_DOWN, DIR_LEFT, DIR_DOWN, DIR_DOWN};
			end
			RGN_BOTTOM_LEFT: begin
				cnt = 2;
				ord = '{DIR_RIGHT, DIR_UP, DIR_DOWN, DIR_DOWN};
			end
			default: begin
				cnt = 2;
				ord = '{DIR_UP, DIR_LEFT, DIR_DOWN, DIR_DOWN};
			end
		endcase
		for (int k = 0; k < 4; k++) begin
			nbr_addr[k] = base;
			if (k < cnt) begin
				case (ord[k])
					DIR_DOWN: nbr_addr[k] = base + MAX_COLS;
					DIR_UP: nbr_addr[k] = base - MAX_COLS;
					DIR_RIGHT: nbr_addr[k] = base + 1;
					default: nbr_addr[k] = base - 1;
				endcase
			end
		end
		return cnt;
	endfunction

	function automatic longint unsigned candidate_cost(input logic [PIX_IO_W-1:0] cand,
			input logic [PIX_IO_W-1:0] obs, input int cnt);
		longint unsigned     dist_sum;
		logic [PIX_IO_W-1:0] nb;
		dist_sum = 0;
		for (int k = 0; k < cnt; k++) begin
			nb = current_img[nbr_addr[k]];
			dist_sum += (cand > nb) ? cand - nb : nb - cand;
		end
		return ((cand != obs) ? MISMATCH_COST : 0) + longint'(weight_q) * dist_sum;
	endfunction

	// Updates the local images and returns the result the block must give.
	function automatic pixel_result_t apply_pixel_cmd(input pixel_cmd_t it);
		pixel_result_t       res;
		int                  nr;
		int                  nc;
		int                  addr;
		int                  cnt;
		logic [PIX_IO_W-1:0] obs;
		logic [PIX_IO_W-1:0] best;
		logic [PIX_IO_W-1:0] cand;
		longint unsigned     best_cost;
		longint unsigned     cost;
		res.pixel_out = '0;
		res.changed = 1'b0;
		res.status = 1'b0;
		nr = eff_dim(rows_q, MAX_ROWS);
		nc = eff_dim(cols_q, MAX_COLS);
		if (it.cmd == CMD_NOP) return res;
		if (it.row >= nr || it.col >= nc) begin
			res.status = 1'b1;
			return res;
		end
		addr = it.row * MAX_COLS + it.col;
		case (it.cmd)
			CMD_LOAD: begin
				observed_img[addr] = it.pixel_in & PIX_IO_W'((64'd1 << PIXEL_BITS) - 1);
				current_img[addr] = observed_img[addr];
				loaded[addr] = 1'b1;
				res.pixel_out = observed_img[addr];
			end
			CMD_READ: res.pixel_out = current_img[addr];
			CMD_UPDATE: begin
				obs = observed_img[addr];
				cnt = gather_neighbors(it.row, it.col, nr, nc);
				best = obs;
				best_cost = candidate_cost(obs, obs, cnt);
				for (int k = 0; k < cnt; k++) begin
					cand = current_img[nbr_addr[k]];
					cost = candidate_cost(cand, obs, cnt);
					if (cost < best_cost) begin
						best_cost = cost;
						best = cand;
					end
				end
				res.changed = (best != current_img[addr]);
				current_img[addr] = best;
				res.pixel_out = best;
			end
			default: ;
		endcase
		return res;
	endfunction

	// A read or update may only touch pixels that were loaded.
	function automatic bit cmd_is_safe(input pixel_cmd_t it);
		int nr;
		int nc;
		int addr;
		int cnt;
		nr = eff_dim(rows_q, MAX_ROWS);
		nc = eff_dim(cols_q, MAX_COLS);
		if (it.row >= nr || it.col >= nc) return 1'b1;
		addr = it.row * MAX_COLS + it.col;
		if (it.cmd == CMD_READ) return loaded[addr];
		if (it.cmd != CMD_UPDATE) return 1'b1;
		if (!loaded[addr]) return 1'b0;
		cnt = gather_neighbors(it.row, it.col, nr, nc);
		for (int k = 0; k < cnt; k++)
			if (!loaded[nbr_addr[k]]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [PIX_IO_W-1:0] pick_pixel();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 3) return PIX_IO_W'($urandom_range(0, 3));
		if (sel < 5) begin
			case ($urandom_range(0, 3))
				0: return '0;
				1: return '1;
				2: return 16'h7FFF;
				default: return 16'h8000;
			endcase
		end
		return PIX_IO_W'($urandom());
	endfunction

	// Large images: stay mostly near the borders so neighborhoods get loaded.
	function automatic int pick_coord(input int n);
		if (n <= 16 || $urandom_range(0, 9) < 3) return $urandom_range(0, n - 1);
		if ($urandom_range(0, 1) == 1) return $urandom_range(0, 2);
		return $urandom_range(n - 3, n - 1);
	endfunction

	function automatic int pick_gap(input bit quiet);
		int sel;
		if (quiet) return 0;
		sel = $urandom_range(0, 99);
		if (sel < 55) return 0;
		if (sel < 88) return $urandom_range(1, 3);
		if (sel < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic pixel_cmd_t random_pixel_cmd();
		pixel_cmd_t it;
		int         nr;
		int         nc;
		int         sel;
		nr = eff_dim(rows_q, MAX_ROWS);
		nc = eff_dim(cols_q, MAX_COLS);
		sel = $urandom_range(0, 99);
		it.pixel_in = pick_pixel();
		it.row = COORD_W'(pick_coord(nr));
		it.col = COORD_W'(pick_coord(nc));
		if (sel < 15) begin
			it.cmd = CMD_LOAD;
		end else if (sel < 65) begin
			it.cmd = CMD_UPDATE;
		end else if (sel < 85) begin
			it.cmd = CMD_READ;
		end else if (sel < 90) begin
			it.cmd = CMD_NOP;
			it.row = COORD_W'($urandom());
			it.col = COORD_W'($urandom());
		end else begin
			it.cmd = cmd_t'($urandom_range(0, 3));
			if (nr < MAX_ROWS && (nc == MAX_COLS || $urandom_range(0, 1) == 1))
				it.row = COORD_W'($urandom_range(nr, MAX_ROWS - 1));
			else if (nc < MAX_COLS)
				it.col = COORD_W'($urandom_range(nc, MAX_COLS - 1));
		end
		if (!cmd_is_safe(it)) it.cmd = CMD_LOAD;
		return it;
	endfunction

	task automatic send_pixel_cmd(input pixel_cmd_t it);
		int gap;
		gap = pick_gap(item_quiet);
		if ($urandom_range(0, 63) == 0) item_quiet = !item_quiet;
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid    <= 1'b1;
		item_ch.command  <= it.cmd;
		item_ch.row      <= it.row;
		item_ch.col      <= it.col;
		item_ch.pixel_in <= it.pixel_in;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		results_due.push_back(apply_pixel_cmd(it));
	endtask

	task automatic send_fields(input cmd_t cmd, input int row, input int col,
			input logic [PIX_IO_W-1:0] pix);
		pixel_cmd_t it;
		it.cmd = cmd;
		it.row = COORD_W'(row);
		it.col = COORD_W'(col);
		it.pixel_in = pix;
		send_pixel_cmd(it);
	endtask

	task automatic wait_results();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			CFG_WEIGHT: weight_q = value[WEIGHT_W-1:0];
			CFG_ROWS: rows_q = value[DIM_REG_W-1:0];
			CFG_COLS: cols_q = value[DIM_REG_W-1:0];
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_geometry(input logic [WEIGHT_W-1:0] w,
			input logic [DIM_REG_W-1:0] nrow, input logic [DIM_REG_W-1:0] ncol);
		wait_results();
		write_register(CFG_WEIGHT, CFG_DATA_W'(w));
		write_register(CFG_ROWS, CFG_DATA_W'(nrow));
		write_register(CFG_COLS, CFG_DATA_W'(ncol));
	endtask

	task automatic fill_image();
		int nr;
		int nc;
		nr = eff_dim(rows_q, MAX_ROWS);
		nc = eff_dim(cols_q, MAX_COLS);
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				send_fields(CMD_LOAD, r, c, pick_pixel());
	endtask

	// Reset sizes and weight: corners at both ends of the coordinate range.
	task automatic test_defaults();
		send_fields(CMD_LOAD, 0, 0, 16'h1234);
		send_fields(CMD_LOAD, 0, 1, 16'h0003);
		send_fields(CMD_LOAD, 1, 0, 16'h0003);
		send_fields(CMD_UPDATE, 0, 0, 16'hFFFF);
		send_fields(CMD_READ, 0, 0, 16'h0000);
		send_fields(CMD_LOAD, 255, 255, 16'hFFFF);
		send_fields(CMD_LOAD, 254, 255, 16'h0000);
		send_fields(CMD_LOAD, 255, 254, 16'hFFFF);
		send_fields(CMD_UPDATE, 255, 255, 16'h5555);
		send_fields(CMD_NOP, 255, 255, 16'hFFFF);
	endtask

	// 3x3 image at full weight: interior, edge, corner, and off-image coordinates.
	task automatic test_smallest_image();
		logic [PIX_IO_W-1:0] pattern [9];
		pattern = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF,
			16'h0001, 16'h0000, 16'hFFFF};
		set_geometry(16'hFFFF, 9'd3, 9'd3);
		for (int k = 0; k < 9; k++)
			send_fields(CMD_LOAD, k / 3, k % 3, pattern[k]);
		send_fields(CMD_UPDATE, 1, 1, 16'h0000);
		send_fields(CMD_UPDATE, 0, 1, 16'hFFFF);
		send_fields(CMD_UPDATE, 2, 2, 16'h0000);
		send_fields(CMD_READ, 1, 1, 16'h0000);
		send_fields(CMD_LOAD, 3, 0, 16'hABCD);
		send_fields(CMD_UPDATE, 0, 3, 16'h0000);
		send_fields(CMD_READ, 255, 255, 16'hFFFF);
	endtask

	task automatic test_random_phases();
		logic [WEIGHT_W-1:0]  w;
		logic [DIM_REG_W-1:0] nrow;
		logic [DIM_REG_W-1:0] ncol;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			w = WEIGHT_W'($urandom());
			nrow = DIM_REG_W'($urandom_range(3, 8));
			ncol = DIM_REG_W'($urandom_range(3, 8));
			case (p)
				0: begin
					w = 16'd256;
					nrow = 9'd3;
					ncol = 9'd3;
				end
				1: begin
					w = 16'd0;
					nrow = 9'd4;
					ncol = 9'd5;
				end
				2: begin
					w = 16'hFFFF;
					nrow = 9'd8;
					ncol = 9'd3;
				end
				3: begin
					w = 16'd1;
					nrow = 9'd0;
					ncol = 9'd2;
				end
				4: begin
					w = 16'd512;
					nrow = 9'd511;
					ncol = 9'd6;
				end
				5: begin
					w = 16'd128;
					nrow = 9'd5;
					ncol = 9'd300;
				end
				6: begin
					nrow = 9'd256;
					ncol = 9'd256;
				end
				7: w = 16'd384;
				9: begin
					w = 16'hFFFF;
					nrow = 9'd256;
					ncol = 9'd256;
				end
				10: begin
					w = 16'd0;
					nrow = 9'd7;
					ncol = 9'd7;
				end
				11: begin
					nrow = 9'd1;
					ncol = 9'd8;
				end
				default: ;
			endcase
			set_geometry(w, nrow, ncol);
			if (p == 3) write_register(CFG_NONE, CFG_DATA_W'($urandom()));
			if (eff_dim(rows_q, MAX_ROWS) * eff_dim(cols_q, MAX_COLS) <= FILL_LIMIT)
				fill_image();
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 99) == 0) wait_results();
				send_pixel_cmd(random_pixel_cmd());
			end
		end
	endtask

	initial begin : result_monitor
		pixel_result_t due;
		res_ch.ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (res_ch.valid && res_ch.ready) begin
					if (results_due.size() == 0) begin
						error_count++;
						$error("result transfer with nothing pending: pixel_out=%h",
							res_ch.pixel_out);
					end else begin
						due = results_due.pop_front();
						if (res_ch.pixel_out !== due.pixel_out) begin
							error_count++;
							$error("pixel_out: expected %h, got %h", due.pixel_out,
								res_ch.pixel_out);
						end
						if (res_ch.changed !== due.changed) begin
							error_count++;
							$error("changed: expected %b, got %b", due.changed, res_ch.changed);
						end
						if (res_ch.status !== due.status) begin
							error_count++;
							$error("status: expected %b, got %b", due.status, res_ch.status);
						end
					end
				end
				if (stall_left > 0) begin
					stall_left--;
					res_ch.ready <= 1'b0;
				end else begin
					res_ch.ready <= 1'b1;
					stall_left = pick_gap(res_quiet);
					if ($urandom_range(0, 63) == 0) res_quiet = !res_quiet;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		weight_q = WEIGHT_RESET;
		rows_q = DIM_RESET;
		cols_q = DIM_RESET;
		arst_n <= 1'b0;
		item_ch.valid    <= 1'b0;
		item_ch.command  <= CMD_LOAD;
		item_ch.row      <= '0;
		item_ch.col      <= '0;
		item_ch.pixel_in <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_WEIGHT;
		cfg_ch.data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_smallest_image();
		test_random_phases();
		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/tvplu_pkg.sv
rtl/core/tvplu_if.sv
rtl/core/tv_pixel_label_update.sv
tb/sv/tb_top.sv
